// ===== hw/rtl/sorted_id_stream_set_op_core_defines.svh =====
// Assertion macros shared by the block's RTL.
`ifndef SORTED_ID_STREAM_SET_OP_CORE_DEFINES_SVH
`define SORTED_ID_STREAM_SET_OP_CORE_DEFINES_SVH

// same-cycle implication
`define SISOP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SISOP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sisop_pkg.sv =====
package sisop_pkg;

  localparam int ACTION_W = 3;
  localparam int IN_ID_W  = 32;
  localparam int ID_RES_W = 32;
  localparam int STATUS_W = 2;
  localparam int OP_W     = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LEFT_ID   = 3'd0,
    ACT_RIGHT_ID  = 3'd1,
    ACT_LEFT_END  = 3'd2,
    ACT_RIGHT_END = 3'd3,
    ACT_CLEAR     = 3'd4
  } action_t;

  typedef enum logic [OP_W-1:0] {
    OP_UNION      = 2'd0,
    OP_INTERSECT  = 2'd1,
    OP_LEFT_MINUS = 2'd2,
    OP_SYM_DIFF   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ID       = 2'd0,
    STAT_DONE     = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEC,
    ST_RD,
    ST_CMP,
    ST_TAIL,
    ST_FRD,
    ST_FEM,
    ST_DONE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic                put;
    logic                close;
    logic [ID_RES_W-1:0] id;
    status_t             status;
  } res_req_t;

endpackage

// ===== hw/rtl/sisop_ifs.sv =====
interface sisop_item_if;
  import sisop_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [IN_ID_W-1:0]  id;
  modport source (output valid, action, id, input ready);
  modport sink (input valid, action, id, output ready);
endinterface

interface sisop_result_if;
  import sisop_pkg::*;
  logic                valid;
  logic                ready;
  logic [ID_RES_W-1:0] id_res;
  logic [STATUS_W-1:0] status;
  logic                last;
  modport source (output valid, id_res, status, last, input ready);
  modport sink (input valid, id_res, status, last, output ready);
endinterface

interface sisop_cfg_if;
  import sisop_pkg::*;
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  modport source (output valid, operation, input ready);
  modport sink (input valid, operation, output ready);
endinterface

// ===== hw/rtl/sorted_id_stream_set_op_core.sv =====
// Merges two ascending ID streams (left and right) into the set selected by
// the operation register: union, intersection, left minus right or symmetric
// difference. The items channel carries one action per item (left id, right
// id, left end, right end, clear); the results channel returns id_res,
// status and last, with last set on the final result of each item. The cfg
// channel writes the operation; ready is always high, write it while idle.
// Unmatched IDs of one side wait in a circular buffer held in a synchronous
// RAM with one read and one write port, PENDING_DEPTH entries deep; an ID
// that finds it full yields one overflow result. Each item is first decoded;
// an ID after its side ended, a repeated end, a clear or an unused action
// ends there. Otherwise each buffered ID compared or flushed takes a RAM
// read step and a compare or emit step; then follow, where they apply, the
// tail step in which an ID is resolved or buffered and the done result, and
// last a closing step that marks the last result. A result reaches the
// output once the next result or the closing step moves it out of staging.
// Synchronous reset empties the buffer, clears both end flags and sets the
// operation to union; no clearing pass is needed. When the receiver stalls,
// one result is held at the output and one in a staging register, and the
// block then waits with items.ready low.
`include "sorted_id_stream_set_op_core_defines.svh"

module sorted_id_stream_set_op_core #(
  parameter int PENDING_DEPTH = 16,
  parameter int ID_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  sisop_item_if.sink     items,
  sisop_result_if.source results,
  sisop_cfg_if.sink      cfg
);
  import sisop_pkg::*;

  localparam int PtrW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  logic                ram_we;
  logic [PtrW-1:0]     ram_waddr;
  logic [ID_WIDTH-1:0] ram_wdata;
  logic [PtrW-1:0]     ram_raddr;
  logic [ID_WIDTH-1:0] ram_rdata;
  res_req_t            req;
  logic                take;

  sisop_ram #(
    .WIDTH(ID_WIDTH),
    .DEPTH(PENDING_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  sisop_ctrl #(
    .PENDING_DEPTH(PENDING_DEPTH),
    .ID_WIDTH(ID_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .items    (items),
    .cfg      (cfg),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .req      (req),
    .take     (take)
  );

  sisop_out u_out (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .take   (take),
    .results(results)
  );

  `SISOP_ASSERT_NOW(a_idle_stage_free, clk, rst, items.ready, take, "staged result blocks idle")
  `SISOP_ASSERT_NOW(a_put_not_close, clk, rst, req.put, !req.close, "put and close together")
  `SISOP_ASSERT_NEXT(a_one_item, clk, rst, items.valid && items.ready, !items.ready, "item overlap")
  `SISOP_ASSERT_NOW(a_close_busy, clk, rst, req.close, !items.ready, "close while idle")

endmodule

// ===== hw/rtl/sisop_ram.sv =====
module sisop_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/sisop_ctrl.sv =====
module sisop_ctrl #(
  parameter int PENDING_DEPTH = 16,
  parameter int ID_WIDTH = 32,
  localparam int PtrW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  sisop_item_if.sink            items,
  sisop_cfg_if.sink             cfg,
  output logic                  ram_we,
  output logic [PtrW-1:0]       ram_waddr,
  output logic [ID_WIDTH-1:0]   ram_wdata,
  output logic [PtrW-1:0]       ram_raddr,
  input  logic [ID_WIDTH-1:0]   ram_rdata,
  output sisop_pkg::res_req_t   req,
  input  logic                  take
);
  import sisop_pkg::*;

  localparam int CntW = $clog2(PENDING_DEPTH + 1);
  localparam logic [CntW-1:0] CntOne = CntW'(1);
  localparam logic [CntW-1:0] CntFull = CntW'(PENDING_DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(PENDING_DEPTH - 1);
  localparam logic [PtrW:0] DepthW = (PtrW + 1)'(PENDING_DEPTH);

  state_t              state, state_next;
  action_t             act;
  logic [ID_WIDTH-1:0] x;
  op_t                 op;
  logic [PtrW-1:0]     head, head_next, head_inc, tail;
  logic [PtrW:0]       tail_sum;
  logic [CntW-1:0]     count, count_next;
  logic                side, side_next;
  logic                l_end, l_end_next;
  logic                r_end, r_end_next;
  logic                s, own_end, other_end;

  function automatic logic keep(input logic sd, input op_t o);
    return sd ? (o == OP_UNION || o == OP_SYM_DIFF) : (o != OP_INTERSECT);
  endfunction

  assign s         = act[0];
  assign own_end   = s ? r_end : l_end;
  assign other_end = s ? l_end : r_end;
  assign head_inc  = (head == PtrLast) ? '0 : head + PtrW'(1);
  assign tail_sum  = {1'b0, head} + (PtrW + 1)'(count);
  assign tail      = (tail_sum >= DepthW) ? PtrW'(tail_sum - DepthW) : PtrW'(tail_sum);

  assign ram_raddr = head;
  assign ram_waddr = tail;
  assign ram_wdata = x;
  assign cfg.ready = 1'b1;

  always_comb begin
    state_next  = state;
    head_next   = head;
    count_next  = count;
    side_next   = side;
    l_end_next  = l_end;
    r_end_next  = r_end;
    req         = '0;
    req.status  = STAT_ID;
    ram_we      = 1'b0;
    items.ready = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (items.valid) begin
          state_next = ST_DEC;
        end
      end
      ST_DEC: begin
        case (act)
          ACT_LEFT_ID, ACT_RIGHT_ID: begin
            if (own_end) begin
              state_next = ST_IDLE;
            end else if (count != '0 && side != s) begin
              state_next = ST_RD;
            end else begin
              state_next = ST_TAIL;
            end
          end
          ACT_LEFT_END, ACT_RIGHT_END: begin
            if (own_end) begin
              state_next = ST_IDLE;
            end else begin
              if (s) begin
                r_end_next = 1'b1;
              end else begin
                l_end_next = 1'b1;
              end
              if (count != '0 && (side != s || other_end)) begin
                state_next = ST_FRD;
              end else if (other_end) begin
                state_next = ST_DONE;
              end else begin
                state_next = ST_FIN;
              end
            end
          end
          ACT_CLEAR: begin
            count_next = '0;
            side_next  = 1'b0;
            l_end_next = 1'b0;
            r_end_next = 1'b0;
            state_next = ST_IDLE;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_RD: state_next = ST_CMP;
      ST_CMP: begin
        if (ram_rdata < x) begin
          req.put = keep(~s, op);
          req.id  = ID_RES_W'(ram_rdata);
          if (!req.put || take) begin
            head_next  = head_inc;
            count_next = count - CntOne;
            state_next = (count == CntOne) ? ST_TAIL : ST_RD;
          end
        end else if (ram_rdata == x) begin
          req.put = (op == OP_UNION || op == OP_INTERSECT);
          req.id  = ID_RES_W'(x);
          if (!req.put || take) begin
            head_next  = head_inc;
            count_next = count - CntOne;
            state_next = ST_FIN;
          end
        end else begin
          req.put = keep(s, op);
          req.id  = ID_RES_W'(x);
          if (!req.put || take) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_TAIL: begin
        if (other_end) begin
          req.put = keep(s, op);
          req.id  = ID_RES_W'(x);
          if (!req.put || take) begin
            state_next = ST_FIN;
          end
        end else if (count == CntFull) begin
          req.put    = 1'b1;
          req.status = STAT_OVERFLOW;
          if (take) begin
            state_next = ST_FIN;
          end
        end else begin
          ram_we     = 1'b1;
          count_next = count + CntOne;
          side_next  = s;
          state_next = ST_FIN;
        end
      end
      ST_FRD: state_next = ST_FEM;
      ST_FEM: begin
        req.put = keep(side, op);
        req.id  = ID_RES_W'(ram_rdata);
        if (!req.put || take) begin
          head_next  = head_inc;
          count_next = count - CntOne;
          if (count == CntOne) begin
            state_next = (l_end && r_end) ? ST_DONE : ST_FIN;
          end else begin
            state_next = ST_FRD;
          end
        end
      end
      ST_DONE: begin
        req.put    = 1'b1;
        req.status = STAT_DONE;
        if (take) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        req.close = 1'b1;
        if (take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      count <= '0;
      side  <= 1'b0;
      l_end <= 1'b0;
      r_end <= 1'b0;
      op    <= OP_UNION;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      side  <= side_next;
      l_end <= l_end_next;
      r_end <= r_end_next;
      if (cfg.valid) begin
        op <= op_t'(cfg.operation);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      act <= action_t'(items.action);
      x   <= ID_WIDTH'(items.id);
    end
  end

endmodule

// ===== hw/rtl/sisop_out.sv =====
module sisop_out (
  input  logic                clk,
  input  logic                rst,
  input  sisop_pkg::res_req_t req,
  output logic                take,
  sisop_result_if.source      results
);
  import sisop_pkg::*;

  logic                stg_valid;
  logic [ID_RES_W-1:0] stg_id;
  status_t             stg_status;
  logic                out_valid;
  logic [ID_RES_W-1:0] out_id;
  status_t             out_status;
  logic                out_last;
  logic                out_free;
  logic                load;

  assign out_free = !out_valid || results.ready;
  assign take     = !stg_valid || out_free;
  assign load     = take && stg_valid && (req.put || req.close);

  assign results.valid  = out_valid;
  assign results.id_res = out_id;
  assign results.status = out_status;
  assign results.last   = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (take && req.put) begin
        stg_valid <= 1'b1;
      end else if (take && req.close) begin
        stg_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_id     <= stg_id;
      out_status <= stg_status;
      out_last   <= req.close;
    end
    if (take && req.put) begin
      stg_id     <= req.id;
      stg_status <= req.status;
    end
  end

endmodule
